// File: src/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 31;
  localparam int unsigned PendW  = 3;
  localparam int unsigned ContW  = 6;

  localparam logic [ByteW-1:0] InvalidLead = 8'hfe;
  localparam logic [1:0]       ContTag     = 2'b10;
  localparam logic [PendW-1:0] PendMax     = 3'd5;

  // Open-sequence state carried between beats.
  typedef struct packed {
    logic [PendW-1:0] pending;
    logic [CpW-1:0]   partial;
  } seq_state_t;

  // One decode result.
  typedef struct packed {
    logic           valid;
    logic [CpW-1:0] code_point;
    logic           error;
  } result_t;

  // Sequence length (1..6) of a lead byte below 0xFE.
  function automatic logic [PendW-1:0] lead_length(input logic [ByteW-1:0] b);
    logic [PendW-1:0] len;
    len = 3'd1;
    unique case (b) inside
      [8'h00:8'hbf]: len = 3'd1;
      [8'hc0:8'hdf]: len = 3'd2;
      [8'he0:8'hef]: len = 3'd3;
      [8'hf0:8'hf7]: len = 3'd4;
      [8'hf8:8'hfb]: len = 3'd5;
      default:       len = 3'd6;
    endcase
    return len;
  endfunction

  // Payload mask of a lead byte, by sequence length.
  function automatic logic [ByteW-1:0] lead_mask(input logic [PendW-1:0] len);
    logic [ByteW-1:0] m;
    m = 8'h00;
    unique case (len)
      3'd1:    m = 8'h7f;
      3'd2:    m = 8'h1f;
      3'd3:    m = 8'h0f;
      3'd4:    m = 8'h07;
      3'd5:    m = 8'h03;
      3'd6:    m = 8'h01;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

endpackage

// File: src/utf8_stream_decoder_unit.sv
// UTF-8 stream decoder (original encoding, sequences of up to six bytes).
//
// Input channel: one byte per beat (data_byte_i, last_byte_i) under
// in_valid_i / in_ready_o. Set last_byte_i on the final byte of a stream;
// a sequence still open after it reports an error.
// Output channel: at most one result per input beat (code_point_o, error_o)
// under out_valid_o / out_ready_i. A result appears when a sequence
// completes, on an invalid lead (0xFE, 0xFF), on a non-continuation byte
// inside a sequence (that byte is dropped too), or on truncation.
//
// Path: the input register feeds one pass of decode logic into the result
// register. Throughput: one byte per cycle sustained while the receiver does
// not stall; the decode step is a shift-or into the accumulator, all
// within one register-to-register path.
//
// Reset clears the open sequence and both register stages. When the
// receiver stalls, the result register holds its beat; the input register
// keeps accepting as long as the byte it holds can move on, i.e. it is a
// byte that yields no result or the result register is empty or draining.
module utf8_stream_decoder_unit
  import utf8d_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_byte_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [CpW-1:0]   code_point_o,
  output logic             error_o
);

  // Input register stage.
  logic             s1_valid_q;
  logic [ByteW-1:0] s1_byte_q;
  logic             s1_last_q;

  // Sequence state and result register.
  seq_state_t       seq_q;
  seq_state_t       seq_d;
  result_t          res_d;
  logic             out_valid_q;
  logic [CpW-1:0]   out_cp_q;
  logic             out_err_q;

  logic out_free;
  logic s1_adv;

  utf8d_step u_step (
    .data_byte_i (s1_byte_q),
    .last_byte_i (s1_last_q),
    .state_i     (seq_q),
    .state_o     (seq_d),
    .result_o    (res_d)
  );

  // The result register can take a new beat when empty or being drained.
  assign out_free   = !out_valid_q || out_ready_i;
  // Advance the held byte when it produces nothing or there is room.
  assign s1_adv     = s1_valid_q && (!res_d.valid || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      seq_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_adv) begin
        seq_q <= seq_d;
      end
      if (out_free) begin
        out_valid_q <= s1_adv && res_d.valid;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= data_byte_i;
      s1_last_q <= last_byte_i;
    end
    if (out_free && s1_adv && res_d.valid) begin
      out_cp_q  <= res_d.code_point;
      out_err_q <= res_d.error;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = out_cp_q;
  assign error_o      = out_err_q;

  // An error beat never carries a code point.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> code_point_o == '0)
    else $error("error result with nonzero code point");

  // At most five continuation bytes are ever outstanding.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_q.pending <= PendMax)
    else $error("pending count out of range");

  // A byte held back by a stalled receiver stays in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_byte_q))
    else $error("held input byte lost");

  // The sequence state changes only when the input register advances.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_adv |=> $stable(seq_q))
    else $error("sequence state changed without an advancing byte");

endmodule

// File: src/utf8d_step.sv
module utf8d_step
  import utf8d_pkg::*;
(
  input  logic [ByteW-1:0] data_byte_i,
  input  logic             last_byte_i,
  input  seq_state_t       state_i,
  output seq_state_t       state_o,
  output result_t          result_o
);

  logic [PendW-1:0] len;
  logic [PendW-1:0] pend_dec;
  logic [CpW-1:0]   acc;

  assign len      = lead_length(data_byte_i);
  assign pend_dec = state_i.pending - 3'd1;
  assign acc      = {state_i.partial[CpW-ContW-1:0], data_byte_i[ContW-1:0]};

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (state_i.pending == '0) begin
      if (data_byte_i >= InvalidLead) begin
        result_o.valid = 1'b1;
        result_o.error = 1'b1;
      end else if (len == 3'd1) begin
        result_o.valid      = 1'b1;
        result_o.code_point = CpW'(data_byte_i & lead_mask(len));
      end else if (last_byte_i) begin
        state_o.partial = '0;
        result_o.valid  = 1'b1;
        result_o.error  = 1'b1;
      end else begin
        state_o.partial = CpW'(data_byte_i & lead_mask(len));
        state_o.pending = len - 3'd1;
      end
    end else if (data_byte_i[7:6] != ContTag) begin
      // drop both the open sequence and this byte
      state_o        = '0;
      result_o.valid = 1'b1;
      result_o.error = 1'b1;
    end else if (pend_dec == '0) begin
      state_o             = '0;
      result_o.valid      = 1'b1;
      result_o.code_point = acc;
    end else if (last_byte_i) begin
      state_o        = '0;
      result_o.valid = 1'b1;
      result_o.error = 1'b1;
    end else begin
      state_o.pending = pend_dec;
      state_o.partial = acc;
    end
  end

endmodule

// File: tb/tb_utf8_stream_decoder_unit.sv
module tb_utf8_stream_decoder_unit
  import utf8d_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Payload mask of a single-byte sequence, stray continuations included.
  localparam logic [ByteW-1:0] PlainMask     = 8'h7f;
  // Longest stretch without a beat on either channel before giving up.
  localparam int unsigned      WatchdogLimit = 2000;
  // Random stream length, counted in bytes sent.
  localparam int unsigned      RandomBytes   = 1430;

  // One expected decode result.
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           err;
  } decode_result_t;

  logic             clk_i        = 1'b0;
  logic             rst_ni       = 1'b0;
  logic             in_valid_i   = 1'b0;
  logic             in_ready_o;
  logic [ByteW-1:0] data_byte_i  = '0;
  logic             last_byte_i  = 1'b0;
  logic             out_valid_o;
  logic             out_ready_i  = 1'b0;
  logic [CpW-1:0]   code_point_o;
  logic             error_o;

  // Decoder shadow state: continuation bytes still owed, payload so far.
  logic [PendW-1:0] pend_cnt  = '0;
  logic [CpW-1:0]   acc_value = '0;

  // Results the decoder owes, oldest first.
  decode_result_t   code_points_q[$];

  int unsigned      mismatches  = 0;
  int unsigned      idle_cycles = 0;
  int unsigned      stall_left  = 0;
  // When set, both sides run flat out: no sender gaps, no receiver stalls.
  logic             quiet_run   = 1'b0;

  utf8_stream_decoder_unit i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .code_point_o (code_point_o),
    .error_o      (error_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Gap or stall length: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_run) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void record_result(input logic [CpW-1:0] cp, input logic err);
    decode_result_t res;
    res.cp  = cp;
    res.err = err;
    code_points_q.push_back(res);
  endfunction

  // Advance the shadow decoder by one accepted byte and queue whatever
  // result that byte completes. The sequence length comes from the count
  // of leading ones in the lead byte; the payload mask is what is left
  // below the terminating zero.
  function automatic void decode_byte(input logic [ByteW-1:0] b, input logic last);
    int unsigned ones;
    ones = 0;
    while (ones < ByteW && b[ByteW-1-ones]) ones++;
    if (pend_cnt == '0) begin
      if (b >= InvalidLead) begin
        // 0xFE / 0xFF never start a sequence
        record_result('0, 1'b1);
      end else if (ones <= 1) begin
        // ASCII, or a stray continuation taken as a one-byte lead
        record_result(CpW'(b & PlainMask), 1'b0);
      end else if (last) begin
        // multi-byte lead on the closing beat: truncated at once
        acc_value = '0;
        record_result('0, 1'b1);
      end else begin
        acc_value = CpW'(b & (8'hff >> (ones + 1)));
        pend_cnt  = PendW'(ones - 1);
      end
    end else if (b[ByteW-1 -: 2] != ContTag) begin
      // broken sequence: drop both the open sequence and this byte
      pend_cnt  = '0;
      acc_value = '0;
      record_result('0, 1'b1);
    end else begin
      acc_value = {acc_value[CpW-1-ContW:0], b[ContW-1:0]};
      pend_cnt  = pend_cnt - 1'b1;
      if (pend_cnt == '0) begin
        record_result(acc_value, 1'b0);
        acc_value = '0;
      end else if (last) begin
        // stream closed with continuation bytes still owed
        pend_cnt  = '0;
        acc_value = '0;
        record_result('0, 1'b1);
      end
    end
  endfunction

  // Send one byte: idle for a random gap, raise valid, hold the payload
  // until the beat is taken, then advance the shadow decoder.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic last);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(b, last);
  endtask

  // Lead byte for a sequence of len bytes with random payload bits.
  function automatic logic [ByteW-1:0] make_lead(input int unsigned len);
    logic [ByteW-1:0] r;
    r = ByteW'($urandom_range(0, 255));
    if (len == 1) return r & PlainMask;
    return ~(8'hff >> len) | (r & (8'hff >> (len + 1)));
  endfunction

  function automatic logic [ByteW-1:0] make_cont();
    return {ContTag, ContW'($urandom_range(0, 63))};
  endfunction

  // ASCII extremes, a stray continuation, and a plain byte that closes a stream.
  task automatic test_single_bytes();
    send_byte(8'h00, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte(8'hbf, 1'b0);
  endtask

  // Both invalid leads; the decoder must stay idle after each.
  task automatic test_invalid_leads();
    send_byte(8'hfe, 1'b0);
    send_byte(8'hff, 1'b1);
  endtask

  // Full-width six-byte code point, and the smallest two-byte overlong form.
  task automatic test_extreme_sequences();
    send_byte(8'hfd, 1'b0);
    repeat (5) send_byte(8'hbf, 1'b0);
    send_byte(8'hc0, 1'b0);
    send_byte(8'h80, 1'b1);
  endtask

  // Non-continuation byte inside a sequence: ASCII, then an invalid lead.
  task automatic test_broken_sequences();
    send_byte(8'he2, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'hc2, 1'b0);
    send_byte(8'hfe, 1'b0);
  endtask

  // Stream closed on a lead byte, and closed one continuation short.
  task automatic test_truncated_sequences();
    send_byte(8'hf0, 1'b1);
    send_byte(8'he2, 1'b0);
    send_byte(8'h82, 1'b1);
  endtask

  // Mostly well-formed sequences of every length with random payload; the
  // rest are truncated or broken sequences and raw noise bytes. Every
  // fourth block runs with neither side idling.
  task automatic test_random_stream();
    int unsigned sent;
    int unsigned kind;
    int unsigned len;
    int unsigned cut;
    logic [ByteW-1:0] junk;
    sent = 0;
    while (sent < RandomBytes) begin
      quiet_run = ((sent / 200) % 4 == 3);
      kind      = $urandom_range(0, 9);
      if (kind < 7) begin
        len = $urandom_range(1, 6);
        send_byte(make_lead(len), (len == 1) && ($urandom_range(0, 9) == 0));
        for (int unsigned i = 1; i < len; i++)
          send_byte(make_cont(), (i == len - 1) && ($urandom_range(0, 9) == 0));
        sent += len;
      end else if (kind < 9) begin
        len = $urandom_range(2, 6);
        cut = $urandom_range(0, len - 2);
        if (kind == 7) begin
          // truncated: close the stream before the last continuation
          send_byte(make_lead(len), cut == 0);
          for (int unsigned i = 1; i <= cut; i++) send_byte(make_cont(), i == cut);
          sent += cut + 1;
        end else begin
          // broken: a non-continuation byte lands mid-sequence
          send_byte(make_lead(len), 1'b0);
          for (int unsigned i = 1; i <= cut; i++) send_byte(make_cont(), 1'b0);
          junk = ByteW'($urandom_range(0, 191));
          if (junk >= 8'h80) junk = junk + 8'h40;
          send_byte(junk, $urandom_range(0, 3) == 0);
          sent += cut + 2;
        end
      end else begin
        send_byte(ByteW'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        sent += 1;
      end
    end
    quiet_run = 1'b0;
  endtask

  // Receiver: accept freely, with random stalls of mostly short length.
  always @(posedge clk_i) begin
    if (quiet_run || stall_left == 0) begin
      out_ready_i <= 1'b1;
      if (!quiet_run && $urandom_range(0, 3) == 0) stall_left = pick_gap();
    end else begin
      out_ready_i <= 1'b0;
      stall_left = stall_left - 1;
    end
  end

  // Compare every result beat, field by field, with the oldest expectation.
  always @(posedge clk_i) begin : result_checker
    decode_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (code_points_q.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual cp=%h err=%b",
                 $time, code_point_o, error_o);
        mismatches++;
      end else begin
        want = code_points_q.pop_front();
        if (code_point_o !== want.cp) begin
          $display("%0t: code_point mismatch: expected %h, actual %h",
                   $time, want.cp, code_point_o);
          mismatches++;
        end
        if (error_o !== want.err) begin
          $display("%0t: error mismatch: expected %b, actual %b",
                   $time, want.err, error_o);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a beat for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, code_points_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    // Hold reset, then release it on a rising edge.
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_bytes();
    test_invalid_leads();
    test_extreme_sequences();
    test_broken_sequences();
    test_truncated_sequences();
    test_random_stream();

    in_valid_i <= 1'b0;
    // Drain: wait for every owed result, then keep watching to catch anything
    // extra the two-stage pipeline might still push out.
    while (code_points_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: utf8_stream_decoder_unit.f
src/utf8d_pkg.sv
src/utf8d_step.sv
src/utf8_stream_decoder_unit.sv
tb/tb_utf8_stream_decoder_unit.sv
